FILE: rtl/skinny128_384_encrypt_macros.svh
// Assertion macros shared by the SKINNY-128-384 checker
`ifndef SKINNY128_384_ENCRYPT_MACROS_SVH
`define SKINNY128_384_ENCRYPT_MACROS_SVH

// check a property on every clock edge outside reset
`define SK128_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// check a property on every clock edge, reset included
`define SK128_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

FILE: rtl/sk128_pkg.sv
// Shared types and constants for the SKINNY-128-384 encryption pipeline
`default_nettype none

package sk128_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TK1_LOW  = 3'd0,
        REG_TK1_HIGH = 3'd1,
        REG_TK2_LOW  = 3'd2,
        REG_TK2_HIGH = 3'd3,
        REG_TK3_LOW  = 3'd4,
        REG_TK3_HIGH = 3'd5
    } cfg_reg_t;

    // byte i of a block sits at element i, byte 0 in bits 7:0
    typedef logic [15:0][7:0] block_t;

    typedef logic [5:0] rc_t;

    localparam rc_t RC_INIT = 6'd0;

    typedef struct packed {
        block_t state;
        block_t tk1;
        block_t tk2;
        block_t tk3;
        rc_t    rc;
    } cell_t;

endpackage

`default_nettype wire

FILE: rtl/sk128_round_cell.sv
// One SKINNY-128-384 round cell: round function, tweakey update and stage register
`default_nettype none

module sk128_round_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            valid_in,
    input  wire sk128_pkg::cell_t d_in,
    output logic                 valid_out,
    output sk128_pkg::cell_t     d_out
);

    localparam logic [7:0] ROW2_CONST = 8'h02;

    // source cell of each tweakey cell after the permutation
    localparam logic [15:0][3:0] TK_PERM = {
        4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0,
        4'd11, 4'd12, 4'd14, 4'd10, 4'd13, 4'd8, 4'd15, 4'd9
    };

    function automatic logic [7:0] sbox_mix(input logic [7:0] x);
        logic [7:0] t;
        t = ~(((x >> 1) | x) >> 2);
        return x ^ (t & 8'h11);
    endfunction

    function automatic logic [7:0] sbox_perm(input logic [7:0] x);
        return ((x & 8'h01) << 2) | ((x & 8'h06) << 5) | ((x & 8'h20) >> 5) |
               ((x & 8'hC8) >> 2) | ((x & 8'h10) >> 1);
    endfunction

    function automatic logic [7:0] sbox8(input logic [7:0] x);
        logic [7:0] y;
        y = sbox_perm(sbox_mix(x));
        y = sbox_perm(sbox_mix(y));
        y = sbox_perm(sbox_mix(y));
        y = sbox_mix(y);
        return (y & 8'hF9) | ((y >> 1) & 8'h02) | ((y << 1) & 8'h04);
    endfunction

    function automatic sk128_pkg::cell_t round_step(input sk128_pkg::cell_t c);
        sk128_pkg::block_t s;
        sk128_pkg::block_t t;
        sk128_pkg::block_t m;
        sk128_pkg::block_t k1;
        sk128_pkg::block_t k2;
        sk128_pkg::block_t k3;
        sk128_pkg::rc_t    rc;
        sk128_pkg::cell_t  r;
        logic [7:0]        a0;
        logic [7:0]        a1;
        logic [7:0]        a2;
        logic [7:0]        a3;
        int                i;
        int                j;
        rc = {c.rc[4:0], c.rc[5] ^ c.rc[4] ^ 1'b1};
        for (i = 0; i < 16; i++)
        begin
            s[i] = sbox8(c.state[i]);
        end
        for (i = 0; i < 8; i++)
        begin
            s[i] = s[i] ^ c.tk1[i] ^ c.tk2[i] ^ c.tk3[i];
        end
        s[0] = s[0] ^ {4'h0, rc[3:0]};
        s[4] = s[4] ^ {6'h0, rc[5:4]};
        s[8] = s[8] ^ ROW2_CONST;
        for (i = 0; i < 4; i++)
        begin
            for (j = 0; j < 4; j++)
            begin
                t[i*4 + j] = s[i*4 + ((j - i) & 3)];
            end
        end
        for (j = 0; j < 4; j++)
        begin
            a0 = t[j];
            a1 = t[4 + j] ^ t[8 + j];
            a2 = t[8 + j] ^ a0;
            a3 = t[12 + j] ^ a2;
            m[j]      = a3;
            m[4 + j]  = a0;
            m[8 + j]  = a1;
            m[12 + j] = a2;
        end
        for (i = 0; i < 16; i++)
        begin
            k1[i] = c.tk1[TK_PERM[i]];
            k2[i] = c.tk2[TK_PERM[i]];
            k3[i] = c.tk3[TK_PERM[i]];
        end
        for (i = 0; i < 8; i++)
        begin
            k2[i] = {k2[i][6:0], k2[i][7] ^ k2[i][5]};
            k3[i] = {k3[i][0] ^ k3[i][6], k3[i][7:1]};
        end
        r.state = m;
        r.tk1   = k1;
        r.tk2   = k2;
        r.tk3   = k3;
        r.rc    = rc;
        return r;
    endfunction

    logic             valid_reg;
    logic             valid_next;
    sk128_pkg::cell_t data_reg;
    sk128_pkg::cell_t data_next;

    always_comb
    begin
        valid_next = en ? valid_in : valid_reg;
        data_next  = en ? round_step(d_in) : data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign d_out     = data_reg;

endmodule

`default_nettype wire

FILE: rtl/skinny128_384_encrypt.sv
// SKINNY-128-384 encryption pipeline: tweakey registers and a chain of round cells
//
// Usage:
//   Write TK1..TK3 through cfg_write/cfg_index/cfg_data while the block is idle;
//   indexes 0..5 select tweak1_low .. tweak3_high, other indexes are ignored.
//   Input beat: plain_low/plain_high with in_valid, taken when in_stall is low.
//   Output beat: cipher_low/cipher_high with out_valid, taken when out_stall is low.
//   The chain holds one round cell per round, each ending in a stage register;
//   each cell carries its block together with its own tweakey copy.
//   Throughput: one block per cycle while the output side keeps taking beats.
//   When the output stalls with a result waiting, the whole chain holds; the
//   first cell still takes a new beat if it is empty, otherwise in_stall rises.
//   Reset clears the tweakey registers to zero and marks every cell empty.
`default_nettype none

module skinny128_384_encrypt #(
    parameter int ROUND_COUNT = 56
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [sk128_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [sk128_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [63:0]                          plain_low,
    input  wire logic [63:0]                          plain_high,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [63:0]                               cipher_low,
    output logic [63:0]                               cipher_high
);

    logic [63:0] tk1_low_reg;
    logic [63:0] tk1_high_reg;
    logic [63:0] tk2_low_reg;
    logic [63:0] tk2_high_reg;
    logic [63:0] tk3_low_reg;
    logic [63:0] tk3_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tk1_low_reg  <= '0;
            tk1_high_reg <= '0;
            tk2_low_reg  <= '0;
            tk2_high_reg <= '0;
            tk3_low_reg  <= '0;
            tk3_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sk128_pkg::REG_TK1_LOW:  tk1_low_reg  <= cfg_data;
                sk128_pkg::REG_TK1_HIGH: tk1_high_reg <= cfg_data;
                sk128_pkg::REG_TK2_LOW:  tk2_low_reg  <= cfg_data;
                sk128_pkg::REG_TK2_HIGH: tk2_high_reg <= cfg_data;
                sk128_pkg::REG_TK3_LOW:  tk3_low_reg  <= cfg_data;
                sk128_pkg::REG_TK3_HIGH: tk3_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    sk128_pkg::cell_t stage_data  [ROUND_COUNT+1];
    logic             stage_valid [ROUND_COUNT+1];
    logic             advance;
    logic             first_en;

    assign advance  = !(stage_valid[ROUND_COUNT] && out_stall);
    assign first_en = advance || !stage_valid[1];
    assign in_stall = !first_en;

    assign stage_valid[0]      = in_valid;
    assign stage_data[0].state = {plain_high, plain_low};
    assign stage_data[0].tk1   = {tk1_high_reg, tk1_low_reg};
    assign stage_data[0].tk2   = {tk2_high_reg, tk2_low_reg};
    assign stage_data[0].tk3   = {tk3_high_reg, tk3_low_reg};
    assign stage_data[0].rc    = sk128_pkg::RC_INIT;

    for (genvar g = 0; g < ROUND_COUNT; g++)
    begin : g_round
        sk128_round_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        ((g == 0) ? first_en : advance),
            .valid_in  (stage_valid[g]),
            .d_in      (stage_data[g]),
            .valid_out (stage_valid[g+1]),
            .d_out     (stage_data[g+1])
        );
    end

    assign out_valid   = stage_valid[ROUND_COUNT];
    assign cipher_low  = stage_data[ROUND_COUNT].state[7:0];
    assign cipher_high = stage_data[ROUND_COUNT].state[15:8];

endmodule

`default_nettype wire

FILE: rtl/sk128_checker.sv
// Port-level assertions for the SKINNY-128-384 encryption pipeline
`default_nettype none

`include "skinny128_384_encrypt_macros.svh"

module sk128_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [63:0] cipher_low,
    input wire logic [63:0] cipher_high
);

    `SK128_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(cipher_low) && $stable(cipher_high), "stalled output beat changed")
    `SK128_ASSERT(a_out_drop, $fell(out_valid) |-> $past(!out_stall), "output beat dropped without being taken")
    `SK128_ASSERT(a_in_stall, in_stall |-> out_valid && out_stall, "input stalled while output side is free")
    `SK128_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output valid right after reset")

endmodule

bind skinny128_384_encrypt sk128_checker u_sk128_checker (.*);

`default_nettype wire
